### rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes shared by the bounded deque controller, datapath and checker.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int OPCODE_W = 3;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_POP_FRONT  = 3'd1,
		OP_PUSH_BACK  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_SEARCH
	} state_t;

	typedef struct packed {
		logic    push_front;
		logic    pop_front;
		logic    push_back;
		logic    pop_back;
		logic    start;
		logic    issue;
		logic    load_out;
		logic    res_found;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic more;
		logic hit;
		logic tail;
	} sts_t;

endpackage

### rtl/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_if
// Request and response channels of the bounded deque, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdq_req_if;
	logic                               valid;
	logic                               ready;
	logic [bdq_pkg::OPCODE_W-1:0]       opcode;
	logic signed [bdq_pkg::VALUE_W-1:0] value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bdq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         found;
	logic [bdq_pkg::STATUS_W-1:0] status;
	logic [bdq_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output found, output status, output count, input ready);
	modport sink   (input valid, input found, input status, input count, output ready);
endinterface

### rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Controller: decodes each request, sequences the search walk and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module bdq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic [bdq_pkg::OPCODE_W-1:0] req_opcode,
	output logic                         req_ready,
	input  logic                         rsp_ready,
	output logic                         rsp_valid,
	input  bdq_pkg::sts_t                sts,
	output bdq_pkg::cmd_t                cmd
);

	bdq_pkg::state_t state_q, state_nxt;
	logic            out_vld_q;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bdq_pkg::S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign req_ready = (state_q == bdq_pkg::S_IDLE) && (!out_vld_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.res_status = bdq_pkg::STAT_DONE;
		case (state_q)
			bdq_pkg::S_IDLE: begin
				if (accept) begin
					cmd.load_out = 1'b1;
					case (req_opcode)
						bdq_pkg::OP_PUSH_FRONT: begin
							if (sts.full) cmd.res_status = bdq_pkg::STAT_FULL;
							else          cmd.push_front = 1'b1;
						end
						bdq_pkg::OP_POP_FRONT: begin
							if (sts.empty) cmd.res_status = bdq_pkg::STAT_EMPTY;
							else           cmd.pop_front = 1'b1;
						end
						bdq_pkg::OP_PUSH_BACK: begin
							if (sts.full) cmd.res_status = bdq_pkg::STAT_FULL;
							else          cmd.push_back = 1'b1;
						end
						bdq_pkg::OP_POP_BACK: begin
							if (sts.empty) cmd.res_status = bdq_pkg::STAT_EMPTY;
							else           cmd.pop_back = 1'b1;
						end
						bdq_pkg::OP_SEARCH: begin
							if (!sts.empty) begin
								cmd.load_out = 1'b0;
								cmd.start    = 1'b1;
								state_nxt    = bdq_pkg::S_SEARCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			bdq_pkg::S_SEARCH: begin
				if (sts.hit) begin
					cmd.load_out  = 1'b1;
					cmd.res_found = 1'b1;
					state_nxt     = bdq_pkg::S_IDLE;
				end else if (sts.tail) begin
					cmd.load_out = 1'b1;
					state_nxt    = bdq_pkg::S_IDLE;
				end else begin
					cmd.issue = sts.more;
				end
			end
			default: begin
				state_nxt = bdq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### rtl/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring store, front pointer, fill count, search read pipeline and
// response payload register.
// ----------------------------------------------------------------------------
module bdq_dp #(
	parameter int DEPTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [bdq_pkg::VALUE_W-1:0]  value,
	input  bdq_pkg::cmd_t                       cmd,
	output bdq_pkg::sts_t                       sts,
	output logic                                found,
	output logic [bdq_pkg::STATUS_W-1:0]        status,
	output logic [bdq_pkg::COUNT_W-1:0]         count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
	localparam logic [CW:0]   DEPTH_W  = (CW + 1)'(DEPTH);

	logic [bdq_pkg::VALUE_W-1:0] mem [DEPTH];

	logic [AW-1:0]               front_q;
	logic [CW-1:0]               fill_q;
	logic [AW-1:0]               rd_ptr_q;
	logic [CW-1:0]               issued_q;
	logic [bdq_pkg::VALUE_W-1:0] key_q;
	logic [bdq_pkg::VALUE_W-1:0] rd_data_s1;
	logic                        vld_s1;
	logic                        last_s1;

	logic [AW-1:0]               front_dec;
	logic [AW-1:0]               front_inc;
	logic [AW-1:0]               rd_inc;
	logic [CW:0]                 back_sum;
	logic [AW-1:0]               back_idx;
	logic [CW-1:0]               fill_nxt;
	logic [CW+bdq_pkg::COUNT_W-1:0] fill_ext;

	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + AW'(1);
	assign rd_inc    = (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
	assign back_sum  = {1'b0, fill_q} + (CW + 1)'(front_q);
	assign back_idx  = (back_sum >= DEPTH_W) ? AW'(back_sum - DEPTH_W) : AW'(back_sum);

	always_comb begin
		fill_nxt = fill_q;
		if (cmd.push_front || cmd.push_back) begin
			fill_nxt = fill_q + CW'(1);
		end else if (cmd.pop_front || cmd.pop_back) begin
			fill_nxt = fill_q - CW'(1);
		end
	end

	assign fill_ext = {{bdq_pkg::COUNT_W{1'b0}}, fill_nxt};

	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			mem[front_dec] <= value;
		end else if (cmd.push_back) begin
			mem[back_idx] <= value;
		end
		if (cmd.issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			fill_q   <= '0;
			rd_ptr_q <= '0;
			issued_q <= '0;
			vld_s1   <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			fill_q <= fill_nxt;
			if (cmd.push_front) begin
				front_q <= front_dec;
			end else if (cmd.pop_front) begin
				front_q <= front_inc;
			end
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				rd_ptr_q <= front_q;
				issued_q <= '0;
			end else if (cmd.issue) begin
				rd_ptr_q <= rd_inc;
				issued_q <= issued_q + CW'(1);
				last_s1  <= (issued_q == fill_q - CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_q <= value;
		end
		if (cmd.load_out) begin
			found  <= cmd.res_found;
			status <= cmd.res_status;
			count  <= fill_ext[bdq_pkg::COUNT_W-1:0];
		end
	end

	assign sts.full  = (fill_q == DEPTH_C);
	assign sts.empty = (fill_q == '0);
	assign sts.more  = (issued_q < fill_q);
	assign sts.hit   = vld_s1 && (rd_data_s1 == key_q);
	assign sts.tail  = vld_s1 && last_s1;

endmodule

### rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit values with front-to-back search.
//
//   channel  role   handshake     payload
//   req      sink   valid/ready   opcode[2:0], value[31:0] signed
//   rsp      source valid/ready   found, status[1:0], count[6:0]
//
// For push, pop, unused opcodes and search of an empty queue the response is
// valid in the cycle after the request is taken.
// Search reads the entries from front to back up to the first match, at most
// DEPTH of them; the single read port of the ring store sets one entry a cycle.
// Reset empties the queue at once; the store itself is not cleared.
// req is taken when idle and the response register is empty or being taken.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
	parameter int DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	bdq_pkg::cmd_t cmd;
	bdq_pkg::sts_t sts;

	bdq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_opcode (req.opcode),
		.req_ready  (req.ready),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.sts        (sts),
		.cmd        (cmd)
	);

	bdq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (req.value),
		.cmd    (cmd),
		.sts    (sts),
		.found  (rsp.found),
		.status (rsp.status),
		.count  (rsp.count)
	);

endmodule

### rtl/bdq_checker.sv
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque, bound to the top level.
// ----------------------------------------------------------------------------
module bdq_checker #(
	parameter int DEPTH = 64
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_found,
	input logic [bdq_pkg::STATUS_W-1:0] rsp_status,
	input logic [bdq_pkg::COUNT_W-1:0]  rsp_count
);

	localparam logic [bdq_pkg::COUNT_W-1:0] DEPTH_CNT = bdq_pkg::COUNT_W'(DEPTH);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=>
			rsp_valid && $stable(rsp_found) && $stable(rsp_status) && $stable(rsp_count))
		else $error("response changed while stalled");

	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |-> rsp_status == bdq_pkg::STAT_DONE)
		else $error("found with non-done status");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bdq_pkg::STAT_EMPTY |-> rsp_count == '0)
		else $error("empty status with nonzero count");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bdq_pkg::STAT_FULL |-> rsp_count == DEPTH_CNT)
		else $error("full status with wrong count");

	a_no_take_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || rsp_ready)
		else $error("transaction taken while response blocked");

endmodule

bind bounded_deque_with_search bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_found  (rsp.found),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.count)
);

### test/bdq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bdq_scoreboard
// Watches the request and response channels of the bounded deque, keeps its
// own ring of entries to predict each response, and compares every field.
// ----------------------------------------------------------------------------
module bdq_scoreboard #(
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	bdq_req_if   req,
	bdq_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   hit_count,
	output int   full_count,
	output int   empty_count
);

	typedef struct packed {
		logic                         found;
		bdq_pkg::status_t             status;
		logic [bdq_pkg::COUNT_W-1:0]  count;
	} outcome_t;

	logic [bdq_pkg::VALUE_W-1:0] ring [DEPTH];
	int unsigned                 head;
	int unsigned                 fill;
	outcome_t                    awaited [$];

	task automatic report(string what);
		fail_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	function automatic outcome_t apply_op(logic [bdq_pkg::OPCODE_W-1:0] op,
		logic [bdq_pkg::VALUE_W-1:0] v);
		outcome_t o;
		o.found  = 1'b0;
		o.status = bdq_pkg::STAT_DONE;
		case (op)
			bdq_pkg::OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					o.status = bdq_pkg::STAT_FULL;
				end else begin
					head = (head + DEPTH - 1) % DEPTH;
					ring[head] = v;
					fill++;
				end
			end
			bdq_pkg::OP_POP_FRONT: begin
				if (fill == 0) begin
					o.status = bdq_pkg::STAT_EMPTY;
				end else begin
					head = (head + 1) % DEPTH;
					fill--;
				end
			end
			bdq_pkg::OP_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					o.status = bdq_pkg::STAT_FULL;
				end else begin
					ring[(head + fill) % DEPTH] = v;
					fill++;
				end
			end
			bdq_pkg::OP_POP_BACK: begin
				if (fill == 0) begin
					o.status = bdq_pkg::STAT_EMPTY;
				end else begin
					fill--;
				end
			end
			bdq_pkg::OP_SEARCH: begin
				for (int k = 0; k < fill; k++) begin
					if (ring[(head + k) % DEPTH] == v) begin
						o.found = 1'b1;
						break;
					end
				end
			end
			default: begin
			end
		endcase
		o.count = bdq_pkg::COUNT_W'(fill);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			head = 0;
			fill = 0;
			awaited.delete();
			pending     = 0;
			fail_count  = 0;
			hit_count   = 0;
			full_count  = 0;
			empty_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					report("response with no transaction awaiting it");
				end else begin
					want = awaited.pop_front();
					if (rsp.found !== want.found)
						report($sformatf("found: got %b, want %b", rsp.found, want.found));
					if (rsp.status !== want.status)
						report($sformatf("status: got %0d, want %0d", rsp.status,
							want.status));
					if (rsp.count !== want.count)
						report($sformatf("count: got %0d, want %0d", rsp.count, want.count));
				end
			end
			if (req.valid && req.ready) begin
				want = apply_op(req.opcode, req.value);
				if (want.found)
					hit_count++;
				if (want.status == bdq_pkg::STAT_FULL)
					full_count++;
				if (want.status == bdq_pkg::STAT_EMPTY)
					empty_count++;
				awaited.push_back(want);
			end
			pending = awaited.size();
		end
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and randomized deque operations into the bounded deque
// with random gaps and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 1000;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AT      = 200;
	localparam int PAUSE_AT     = 500;
	localparam int STEADY_FROM  = 600;
	localparam int STEADY_TO    = 760;

	localparam logic [bdq_pkg::OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [bdq_pkg::OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [bdq_pkg::OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [bdq_pkg::VALUE_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [bdq_pkg::VALUE_W-1:0] V_MAX  = 32'h7fff_ffff;
	localparam logic [bdq_pkg::VALUE_W-1:0] V_ZERO = 32'h0000_0000;
	localparam logic [bdq_pkg::VALUE_W-1:0] V_ONES = 32'hffff_ffff;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_t;

	logic clk;
	logic arst_n;
	logic steady;
	int   sent;
	int   hold_ask;
	int   fail_count, pending, hit_count, full_count, empty_count;

	logic [bdq_pkg::VALUE_W-1:0] pool [32];
	int                          pool_wr;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_deque_with_search #(.DEPTH(DEPTH)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bdq_scoreboard #(.DEPTH(DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.hit_count   (hit_count),
		.full_count  (full_count),
		.empty_count (empty_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	initial begin
		#4_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send(input logic [bdq_pkg::OPCODE_W-1:0] op,
		input logic [bdq_pkg::VALUE_W-1:0] v);
		while (!steady && $urandom_range(99) < 24) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= op;
		req_ch.value  <= v;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	function automatic logic [bdq_pkg::VALUE_W-1:0] pick_push_value();
		case ($urandom_range(19))
			0: return V_MIN;
			1: return V_MAX;
			2: return V_ZERO;
			3: return V_ONES;
			4, 5: return pool[$urandom_range(31)];
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [bdq_pkg::VALUE_W-1:0] pick_search_value();
		case ($urandom_range(19))
			0: return V_MIN;
			1: return V_MAX;
			2: return V_ONES;
			3, 4, 5, 6, 7: return $urandom();
			default: return pool[$urandom_range(31)];
		endcase
	endfunction

	function automatic logic [bdq_pkg::OPCODE_W-1:0] pick_op(mode_t mode);
		int r;
		r = $urandom_range(99);
		if (r < 4) begin
			case ($urandom_range(2))
				0: return OP_SPARE_5;
				1: return OP_SPARE_6;
				default: return OP_SPARE_7;
			endcase
		end
		case (mode)
			MODE_FILL: begin
				if (r < 72)
					return $urandom_range(1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
				if (r < 90)
					return bdq_pkg::OP_SEARCH;
				return $urandom_range(1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
			end
			MODE_DRAIN: begin
				if (r < 72)
					return $urandom_range(1) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
				if (r < 90)
					return bdq_pkg::OP_SEARCH;
				return $urandom_range(1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
			end
			default: begin
				if (r < 24)
					return bdq_pkg::OP_PUSH_FRONT;
				if (r < 44)
					return bdq_pkg::OP_PUSH_BACK;
				if (r < 58)
					return bdq_pkg::OP_POP_FRONT;
				if (r < 72)
					return bdq_pkg::OP_POP_BACK;
				return bdq_pkg::OP_SEARCH;
			end
		endcase
	endfunction

	// drop ready for a counted stretch on request, hold it high in the steady window, otherwise stall at random
	initial begin
		int left;
		int seen;
		left = 0;
		seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_ask != seen) begin
				seen = hold_ask;
				left = HOLD_CYCLES;
			end
			if (left > 0) begin
				left--;
				rsp_ch.ready <= 1'b0;
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= 24);
			end
		end
	end

	initial begin
		mode_t                        mode;
		int                           len;
		logic [bdq_pkg::OPCODE_W-1:0] op;
		logic [bdq_pkg::VALUE_W-1:0]  v;

		arst_n        = 1'b0;
		steady        = 1'b0;
		sent          = 0;
		hold_ask      = 0;
		pool_wr       = 0;
		req_ch.valid  = 1'b0;
		req_ch.opcode = bdq_pkg::OP_SEARCH;
		req_ch.value  = V_ZERO;
		foreach (pool[i])
			pool[i] = $urandom();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(bdq_pkg::OP_SEARCH, V_ZERO);
		send(bdq_pkg::OP_POP_FRONT, V_MAX);
		send(bdq_pkg::OP_POP_BACK, V_MIN);
		send(OP_SPARE_5, V_ONES);
		send(OP_SPARE_6, V_ZERO);
		send(OP_SPARE_7, V_MIN);
		send(bdq_pkg::OP_PUSH_FRONT, V_MIN);
		send(bdq_pkg::OP_PUSH_BACK, V_MAX);
		send(bdq_pkg::OP_PUSH_FRONT, V_ZERO);
		send(bdq_pkg::OP_PUSH_BACK, V_ONES);
		send(bdq_pkg::OP_SEARCH, V_MIN);
		send(bdq_pkg::OP_SEARCH, V_MAX);
		send(bdq_pkg::OP_SEARCH, V_ONES);
		send(bdq_pkg::OP_SEARCH, 32'h1234_5678);
		send(bdq_pkg::OP_SEARCH, V_ZERO);
		send(bdq_pkg::OP_POP_FRONT, V_ZERO);
		send(bdq_pkg::OP_SEARCH, V_ZERO);
		send(bdq_pkg::OP_POP_BACK, V_ZERO);
		send(bdq_pkg::OP_POP_BACK, V_ZERO);
		send(bdq_pkg::OP_POP_FRONT, V_ZERO);
		send(bdq_pkg::OP_POP_FRONT, V_ZERO);
		send(bdq_pkg::OP_PUSH_BACK, 32'h5555_5555);
		send(bdq_pkg::OP_POP_FRONT, 32'haaaa_aaaa);

		while (sent < RANDOM_ITEMS + 23) begin
			case ($urandom_range(2))
				0: mode = MODE_FILL;
				1: mode = MODE_DRAIN;
				default: mode = MODE_MIXED;
			endcase
			len = (mode == MODE_MIXED) ? $urandom_range(20, 80) : $urandom_range(60, 140);
			for (int i = 0; i < len && sent < RANDOM_ITEMS + 23; i++) begin
				if (sent == HOLD_AT)
					hold_ask++;
				if (sent == PAUSE_AT) begin
					req_ch.valid <= 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				steady = (sent >= STEADY_FROM && sent < STEADY_TO);
				op = pick_op(mode);
				if (op == bdq_pkg::OP_PUSH_FRONT || op == bdq_pkg::OP_PUSH_BACK) begin
					v = pick_push_value();
					pool[pool_wr % 32] = v;
					pool_wr++;
				end else begin
					v = pick_search_value();
				end
				send(op, v);
			end
		end
		steady = 1'b0;
		req_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DEPTH + 16) @(posedge clk);
		$display("%0d transactions: directed edge cases, then fill, drain and mixed runs",
			sent);
		$display("searches hit %0d, pushes refused full %0d, pops on empty %0d",
			hit_count, full_count, empty_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_ctrl.sv
rtl/bdq_dp.sv
rtl/bounded_deque_with_search.sv
rtl/bdq_checker.sv
test/bdq_checker.sv
test/tb_top.sv
